// ----- hw/rtl/mwo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared constants, codes and the quarter-wave sine table of the oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_AW     = $clog2(SINE_DEPTH);
    localparam int SINE_IW     = SINE_AW + 1;
    localparam int WAVE_W      = 16;
    localparam int VOL_W       = 15;
    localparam int SEL_W       = 3;
    localparam int LFSR_W      = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [SEL_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [SEL_W-1:0] WAVE_SAWTOOTH = 3'd1;
    localparam logic [SEL_W-1:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [SEL_W-1:0] WAVE_SQUARE   = 3'd3;
    localparam logic [SEL_W-1:0] WAVE_NOISE    = 3'd4;

    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_WAVEFORM   = 2'd1;
    localparam logic [1:0] REG_VOLUME     = 2'd2;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = 32'd42852281;
    localparam logic [SEL_W-1:0]      WAVEFORM_RST   = WAVE_SQUARE;
    localparam logic [VOL_W-1:0]      VOLUME_RST     = 15'd1000;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [VOL_W-1:0] sine_tab_t [SINE_DEPTH+1];

    // min(32767, round(32768 * sin(pi/2 * k / depth))), Q30 Taylor series of degree 11
    function automatic sine_tab_t sine_build();
        sine_tab_t   tab;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] r;
        logic [63:0] s;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            t  = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
            t2 = (t * t) >> 30;
            r  = Q30_ONE;
            r  = Q30_ONE - ((t2 * r) >> 30) / 110;
            r  = Q30_ONE - ((t2 * r) >> 30) / 72;
            r  = Q30_ONE - ((t2 * r) >> 30) / 42;
            r  = Q30_ONE - ((t2 * r) >> 30) / 20;
            r  = Q30_ONE - ((t2 * r) >> 30) / 6;
            s  = (t * r) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32767)
            begin
                s = 64'd32767;
            end
            tab[k] = s[VOL_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = sine_build();

    function automatic logic signed [WAVE_W-1:0] clamp18(input logic signed [17:0] v);
        if (v > 18'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            return 16'sh8000;
        end
        return v[WAVE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/multi_waveform_oscillator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Phase-accumulator oscillator with sine, sawtooth, triangle, square and
// noise outputs, volume scaling and APB register access.
// ----------------------------------------------------------------------------
// Each transfer on the input stream with tick set advances a 32-bit phase by
// phase_step and yields one signed 16-bit sample on the output stream; a
// transfer with tick clear is consumed and yields nothing. One sample per
// clock is sustained while the output does not stall: the phase add is the
// only feedback loop. A sample passes one register stage each for phase
// update, wave forming with the sine table, and volume multiply and
// saturation, and is held in place while the output stalls.
// Registers: phase_step at 0x0, waveform at 0x4, volume at 0x8; write them
// only while no sample is in flight.
module multi_waveform_oscillator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [0] tick, [7:1] zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,   // [15:0] sample
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mwo_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mwo_pkg::DATA_W-1:0]    pwdata,
    output logic [mwo_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import mwo_pkg::*;

    logic [PHASE_BITS-1:0]      phase_step_reg;
    logic [SEL_W-1:0]           waveform_reg;
    logic [VOL_W-1:0]           volume_reg;
    logic [PHASE_BITS-1:0]      phase_acc_reg;
    logic [PHASE_BITS-1:0]      phase_acc_next;
    logic [LFSR_W-1:0]          lfsr_reg;
    logic [LFSR_W-1:0]          lfsr_next;
    logic                       lfsr_fb;

    logic                       v1_reg;
    logic [PHASE_BITS-1:0]      p1_reg;
    logic [LFSR_W-1:0]          n1_reg;
    logic                       v2_reg;
    logic signed [WAVE_W-1:0]   w2_reg;
    logic                       v3_reg;
    logic [WAVE_W-1:0]          s3_reg;

    logic                       rdy1;
    logic                       rdy2;
    logic                       rdy3;
    logic                       s_fire;
    logic                       tick_fire;
    logic                       cfg_wr;
    logic signed [WAVE_W-1:0]   wave;
    logic signed [31:0]         prod;
    logic signed [16:0]         scaled;

    // APB registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            waveform_reg   <= WAVEFORM_RST;
            volume_reg     <= VOLUME_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PHASE_STEP: phase_step_reg <= pwdata;
                REG_WAVEFORM:   waveform_reg   <= pwdata[SEL_W-1:0];
                REG_VOLUME:     volume_reg     <= pwdata[VOL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PHASE_STEP: prdata = phase_step_reg;
            REG_WAVEFORM:   prdata = {{(DATA_W-SEL_W){1'b0}}, waveform_reg};
            REG_VOLUME:     prdata = {{(DATA_W-VOL_W){1'b0}}, volume_reg};
            default:        prdata = '0;
        endcase
    end

    // per-stage flow control
    assign rdy3      = !v3_reg || m_tready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign s_tready  = rdy1;
    assign s_fire    = s_tvalid && s_tready;
    assign tick_fire = s_fire && s_tdata[0];

    // stage 1: phase accumulator and noise register
    assign phase_acc_next = phase_acc_reg + phase_step_reg;
    assign lfsr_fb        = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign lfsr_next      = (waveform_reg == WAVE_NOISE) ? {lfsr_fb, lfsr_reg[LFSR_W-1:1]}
                                                         : lfsr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            lfsr_reg      <= '1;
        end
        else if (tick_fire)
        begin
            phase_acc_reg <= phase_acc_next;
            lfsr_reg      <= lfsr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= tick_fire;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            p1_reg <= phase_acc_next;
            n1_reg <= lfsr_next;
        end
        if (rdy2 && v1_reg)
        begin
            w2_reg <= wave;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= clamp18({scaled[16], scaled});
        end
    end

    // stage 2: wave forming
    mwo_wave u_wave (
        .waveform (waveform_reg),
        .phase    (p1_reg),
        .noise    (n1_reg),
        .wave     (wave)
    );

    // stage 3: volume scaling, round half up, saturate
    assign prod   = (w2_reg * $signed({1'b0, volume_reg})) + 32'sd16384;
    assign scaled = prod[31:15];

    assign m_tvalid = v3_reg;
    assign m_tdata  = s3_reg;

`ifndef SYNTHESIS
    a_idle_tick_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !s_tdata[0]) |=> $stable(phase_acc_reg))
        else $error("phase moved on a transfer without tick");

    a_tick_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> v1_reg)
        else $error("accepted tick did not enter the pipeline");

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("noise register locked at zero");

    a_stall_holds_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !m_tready) |=> (v3_reg && $stable(s3_reg)))
        else $error("stalled sample lost");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/mwo_wave.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwo_wave
// Forms the Q1.15 unit wave from the phase, the waveform select and the
// current noise register value.
// ----------------------------------------------------------------------------
module mwo_wave (
    input  wire logic [mwo_pkg::SEL_W-1:0]         waveform,
    input  wire logic [mwo_pkg::PHASE_BITS-1:0]    phase,
    input  wire logic [mwo_pkg::LFSR_W-1:0]        noise,
    output logic signed [mwo_pkg::WAVE_W-1:0]      wave
);
    import mwo_pkg::*;

    logic [SINE_AW+1:0]         sine_i;
    logic [1:0]                 quad;
    logic [SINE_IW-1:0]         sine_k;
    logic [VOL_W-1:0]           sine_mag;
    logic signed [WAVE_W-1:0]   sine_val;
    logic signed [17:0]         saw_raw;
    logic signed [17:0]         tri_raw;
    logic [16:0]                half_ph;

    assign sine_i = phase[PHASE_BITS-1 -: (SINE_AW+2)];
    assign quad   = sine_i[SINE_AW+1:SINE_AW];

    always_comb
    begin
        if (quad[0])
        begin
            sine_k = SINE_IW'(SINE_DEPTH) - {1'b0, sine_i[SINE_AW-1:0]};
        end
        else
        begin
            sine_k = {1'b0, sine_i[SINE_AW-1:0]};
        end
    end

    assign sine_mag = SINE_TAB[sine_k];
    assign sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    assign half_ph = phase[PHASE_BITS-1 -: 17];
    assign saw_raw = 18'sd32768 - $signed({2'b00, phase[PHASE_BITS-1 -: 16]});
    assign tri_raw = phase[PHASE_BITS-1] ? (18'sd98304 - $signed({1'b0, half_ph}))
                                         : ($signed({1'b0, half_ph}) - 18'sd32768);

    always_comb
    begin
        unique case (waveform)
            WAVE_SINE:     wave = sine_val;
            WAVE_SAWTOOTH: wave = clamp18(saw_raw);
            WAVE_TRIANGLE: wave = clamp18(tri_raw);
            WAVE_SQUARE:   wave = phase[PHASE_BITS-1] ? 16'sh8000 : 16'sh7FFF;
            WAVE_NOISE:    wave = $signed({1'b0, noise[LFSR_W-1:1]});
            default:       wave = '0;
        endcase
    end

endmodule
`default_nettype wire
